/* src/jbsm_pkg.sv */
package jbsm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TARGET_W = 4;
    localparam int CMD_W    = 2;
    localparam int PEER_W   = 2;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 4'd4;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH      = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_CLEAR_ONE = 2'd2,
        CMD_CLEAR_ALL = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_EMIT,
        ST_UPDATE
    } t_state;

    // Control of the shared saturating accumulator.
    typedef struct packed {
        logic clr;
        logic add;
    } t_acc_ctrl;

endpackage

/* src/jbsm_sat_acc.sv */
module jbsm_sat_acc
    import jbsm_pkg::*;
(
    input  logic                       i_clk,
    input  t_acc_ctrl                  i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_operand,
    output logic signed [SAMPLE_W-1:0] o_acc
);

    logic signed [SAMPLE_W-1:0] r_acc;
    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W-1:0] sat;

    // One add, then clamp: overflow shows as the two top bits disagreeing.
    always_comb begin
        sum = {r_acc[SAMPLE_W-1], r_acc} + {i_operand[SAMPLE_W-1], i_operand};
        if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
            sat = sum[SAMPLE_W] ? SAT_MIN : SAT_MAX;
        end else begin
            sat = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (i_ctrl.add) begin
            r_acc <= sat;
        end
    end

    assign o_acc = r_acc;

endmodule

/* src/jitter_buffer_saturating_mixer_core.sv */
// Jitter buffer with a saturating mixer over PEERS slots.
//
// Input channel (s_axis): one item per command. tuser carries the command and
// the slot index, tdata the sample to push. Push, clear-one and clear-all never
// hold the block busy; tready is low only while a mix is running.
// A mix tick takes the block over: every output position visits all slots in
// slot order, one store read and one pass through the shared saturating adder
// per slot, then one step to load the output register; one last step retires
// the frames.
// Output channel (m_axis): FRAME_SAMPLES items per tick, tlast on the final
// one. A stalled receiver holds the sequencer in its emit step; the item
// waits in the output register and no sample is lost.
// Configuration: i_cfg_wr_en writes target_frames at once; write it only
// while the block is idle.
// Reset (synchronous, active low) empties all slots, drops their ready and
// take flags and loads target_frames with 4. The sample store is not cleared:
// only entries that were pushed ever reach the mix, so there is no clearing pass.
module jitter_buffer_saturating_mixer_core
    import jbsm_pkg::*;
#(
    parameter int PEERS         = 4,
    parameter int FRAME_SAMPLES = 64,
    parameter int MAX_FRAMES    = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [15:0]         i_s_axis_tdata,  // [15:0] sample_in
    input  logic [3:0]          i_s_axis_tuser,  // [1:0] cmd, [3:2] peer
    // result items
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [15:0]         o_m_axis_tdata,  // [15:0] mixed_sample
    output logic                o_m_axis_tlast,
    // configuration
    input  logic                i_cfg_wr_en,
    input  logic [TARGET_W-1:0] i_cfg_wr_data
);

    localparam int CAP   = FRAME_SAMPLES * MAX_FRAMES;
    localparam int DEPTH = PEERS * CAP;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(CAP);
    localparam int CW    = $clog2(CAP + 2);
    localparam int PIW   = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int SIW   = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
    localparam int TW    = TARGET_W + $clog2(FRAME_SAMPLES + 1);
    localparam int CMPW  = (CW > TW) ? CW : TW;

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [TARGET_W-1:0]   r_target;
    logic [PW-1:0]         r_rp    [PEERS];
    logic [CW-1:0]         r_fill  [PEERS];
    logic                  r_ready [PEERS];
    logic                  r_take  [PEERS];
    logic [PIW-1:0]        r_peer_idx;
    logic [SIW-1:0]        r_samp_idx;
    logic                  r_m_tvalid;
    logic [SAMPLE_W-1:0]   r_m_tdata;
    logic                  r_m_tlast;

    logic [SAMPLE_W-1:0]   mem [DEPTH];
    logic [SAMPLE_W-1:0]   r_rd_data;

    // ---------------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------------
    logic                  in_acc;
    t_cmd                  in_cmd;
    logic [PEER_W-1:0]     in_peer;
    logic                  peer_ok;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd  = t_cmd'(i_s_axis_tuser[CMD_W-1:0]);
    assign in_peer = i_s_axis_tuser[CMD_W+PEER_W-1:CMD_W];
    assign peer_ok = (32'(in_peer) < PEERS);

    // One slot is looked at per cycle: the pushed one while idle, the
    // visited one while mixing.
    logic [PIW-1:0]        sel_peer;
    logic [PW-1:0]         sel_rp;
    logic [CW-1:0]         sel_fill;

    assign sel_peer = (r_state == ST_IDLE) ? PIW'(in_peer) : r_peer_idx;
    assign sel_rp   = r_rp[sel_peer];
    assign sel_fill = r_fill[sel_peer];

    // Thresholds in samples: target*FS for prefill, (target/2)*FS for low water.
    logic [CMPW-1:0]       tgt_samples;
    logic [CMPW-1:0]       low_samples;

    assign tgt_samples = CMPW'(r_target) * CMPW'(FRAME_SAMPLES);
    assign low_samples = CMPW'(r_target >> 1) * CMPW'(FRAME_SAMPLES);

    // ---------------------------------------------------------------------
    // Store addressing: slot base plus circular position
    // ---------------------------------------------------------------------
    logic [PW:0]           wr_sum;
    logic [PW:0]           rd_sum;
    logic [PW-1:0]         wr_pos;
    logic [PW-1:0]         rd_pos;
    logic [AW-1:0]         mem_addr;

    always_comb begin
        wr_sum = (PW+1)'(sel_rp) + (PW+1)'(sel_fill);
        rd_sum = (PW+1)'(sel_rp) + (PW+1)'(r_samp_idx);
        if (wr_sum >= (PW+1)'(CAP)) begin
            wr_sum = wr_sum - (PW+1)'(CAP);
        end
        if (rd_sum >= (PW+1)'(CAP)) begin
            rd_sum = rd_sum - (PW+1)'(CAP);
        end
        wr_pos   = wr_sum[PW-1:0];
        rd_pos   = rd_sum[PW-1:0];
        mem_addr = AW'(sel_peer) * AW'(CAP)
                 + AW'((r_state == ST_IDLE) ? wr_pos : rd_pos);
    end

    // Push bookkeeping for the selected slot.
    logic [CW-1:0]         push_fill;
    logic [PW-1:0]         push_rp;

    assign push_fill = sel_fill + CW'(1);
    assign push_rp   = (sel_rp == PW'(CAP - 1)) ? '0 : sel_rp + PW'(1);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    t_acc_ctrl             acc_ctrl;
    logic                  mem_we;
    logic                  out_load;
    logic                  last_peer;
    logic                  last_samp;
    logic signed [SAMPLE_W-1:0] acc_val;

    assign last_peer = (r_peer_idx == PIW'(PEERS - 1));
    assign last_samp = (r_samp_idx == SIW'(FRAME_SAMPLES - 1));

    always_comb begin
        n_state      = r_state;
        acc_ctrl.clr = 1'b0;
        acc_ctrl.add = 1'b0;
        mem_we       = 1'b0;
        out_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        CMD_PUSH: begin
                            mem_we = peer_ok;
                        end
                        CMD_TICK: begin
                            acc_ctrl.clr = 1'b1;
                            n_state      = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                // silence from a slot that gives no frame
                acc_ctrl.add = r_take[r_peer_idx];
                n_state      = last_peer ? ST_EMIT : ST_READ;
            end
            ST_EMIT: begin
                out_load = !r_m_tvalid || i_m_axis_tready;
                if (out_load) begin
                    acc_ctrl.clr = 1'b1;
                    n_state      = last_samp ? ST_UPDATE : ST_READ;
                end
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shared saturating adder.
    jbsm_sat_acc u_sat_acc (
        .i_clk     (i_clk),
        .i_ctrl    (acc_ctrl),
        .i_operand (signed'(r_rd_data)),
        .o_acc     (acc_val)
    );

    // ---------------------------------------------------------------------
    // Sample store: one port, registered read
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_s_axis_tdata;
        end
        r_rd_data <= mem[mem_addr];
    end

    // ---------------------------------------------------------------------
    // Counters and configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= TARGET_RESET;
            r_peer_idx <= '0;
            r_samp_idx <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            if (in_acc && in_cmd == CMD_TICK) begin
                r_peer_idx <= '0;
                r_samp_idx <= '0;
            end
            if (r_state == ST_ACC) begin
                r_peer_idx <= last_peer ? '0 : r_peer_idx + PIW'(1);
            end
            if (out_load) begin
                r_samp_idx <= r_samp_idx + SIW'(1);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Per-slot bookkeeping
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PEERS; p++) begin
                r_rp[p]    <= '0;
                r_fill[p]  <= '0;
                r_ready[p] <= 1'b0;
                r_take[p]  <= 1'b0;
            end
        end else if (in_acc) begin
            case (in_cmd)
                CMD_PUSH: begin
                    if (peer_ok) begin
                        if (CMPW'(push_fill) >= tgt_samples) begin
                            r_ready[sel_peer] <= 1'b1;
                        end
                        // full slot: drop the oldest sample
                        if (push_fill > CW'(CAP)) begin
                            r_rp[sel_peer]   <= push_rp;
                            r_fill[sel_peer] <= CW'(CAP);
                        end else begin
                            r_fill[sel_peer] <= push_fill;
                        end
                    end
                end
                CMD_TICK: begin
                    // decide which slots give a frame on this tick
                    for (int p = 0; p < PEERS; p++) begin
                        r_take[p] <= r_ready[p] && (r_fill[p] >= CW'(FRAME_SAMPLES));
                    end
                end
                CMD_CLEAR_ONE: begin
                    if (peer_ok) begin
                        r_rp[sel_peer]    <= '0;
                        r_fill[sel_peer]  <= '0;
                        r_ready[sel_peer] <= 1'b0;
                        r_take[sel_peer]  <= 1'b0;
                    end
                end
                CMD_CLEAR_ALL: begin
                    for (int p = 0; p < PEERS; p++) begin
                        r_rp[p]    <= '0;
                        r_fill[p]  <= '0;
                        r_ready[p] <= 1'b0;
                        r_take[p]  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == ST_UPDATE) begin
            // retire the frame of every contributing slot
            for (int p = 0; p < PEERS; p++) begin
                logic [PW:0]   upd_rp;
                logic [CW-1:0] upd_fill;
                upd_rp   = (PW+1)'(r_rp[p]) + (PW+1)'(FRAME_SAMPLES);
                upd_fill = r_fill[p] - CW'(FRAME_SAMPLES);
                if (upd_rp >= (PW+1)'(CAP)) begin
                    upd_rp = upd_rp - (PW+1)'(CAP);
                end
                if (r_take[p]) begin
                    r_rp[p]   <= upd_rp[PW-1:0];
                    r_fill[p] <= upd_fill;
                    if (CMPW'(upd_fill) < low_samples) begin
                        r_ready[p] <= 1'b0;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= acc_val;
            r_m_tlast <= last_samp;
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tlast  = r_m_tlast;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_tick_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_cmd == CMD_TICK) |=>
            (r_state == ST_READ && r_peer_idx == '0 && r_samp_idx == '0))
        else $error("mix tick did not start at slot 0, position 0");

    a_frame_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && last_samp) |=>
            (r_state == ST_UPDATE && o_m_axis_tvalid && o_m_axis_tlast))
        else $error("final mixed item not flagged or frame not retired");

    a_no_load_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && !i_m_axis_tready) |-> !out_load)
        else $error("output register overwritten while stalled");

    for (genvar g = 0; g < PEERS; g++) begin : g_fill_chk
        a_fill_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_fill[g] <= CW'(CAP))
            else $error("slot fill count beyond capacity");
    end

endmodule
